// ===== rtl/gcrdf_pkg.sv =====
// Shared types, constants and the 6-and-2 inverse code table for the GCR sector deframer.
// Used by gcrdf_ctrl and gcr_6and2_sector_deframer; depends on nothing.
package gcrdf_pkg;

    // Field marks
    localparam logic [7:0] MARK_D5 = 8'hD5;
    localparam logic [7:0] MARK_AA = 8'hAA;
    localparam logic [7:0] MARK_96 = 8'h96;
    localparam logic [7:0] MARK_DE = 8'hDE;
    localparam logic [7:0] MARK_AD = 8'hAD;

    // 4-and-4 pair masks
    localparam logic [7:0] PAIR_HI_MASK = 8'hAA;
    localparam logic [7:0] PAIR_LO_MASK = 8'h55;

    // Data field geometry
    localparam int unsigned LOW_COUNT  = 86;
    localparam int unsigned DATA_COUNT = 342;
    localparam int unsigned CNT_W      = 9;
    localparam int unsigned LOW_AW     = $clog2(LOW_COUNT);
    localparam int unsigned GRP_W      = 2;
    localparam int unsigned LOW_W      = 6;

    localparam logic [CNT_W-1:0]  CNT_LOW_END  = CNT_W'(LOW_COUNT);
    localparam logic [CNT_W-1:0]  CNT_DATA_END = CNT_W'(DATA_COUNT);
    localparam logic [LOW_AW-1:0] SLOT_LAST    = LOW_AW'(LOW_COUNT - 1);

    // Unit steps for the data counters
    localparam logic [CNT_W-1:0]  CNT_STEP  = CNT_W'(1);
    localparam logic [LOW_AW-1:0] SLOT_STEP = LOW_AW'(1);
    localparam logic [GRP_W-1:0]  GRP_STEP  = GRP_W'(1);

    // Per-item request from the framer to the store and output stage
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [LOW_AW-1:0] addr;
        logic [LOW_W-1:0]  chain;
        logic [7:0]        idx;
        logic [GRP_W-1:0]  grp;
        logic [7:0]        track;
        logic [7:0]        sector;
    } mem_req_t;

    // Map a disk nibble back to its 6-bit value; nibbles outside the code give 0
    function automatic logic [LOW_W-1:0] gcr_inverse(input logic [7:0] nib);
        logic [LOW_W-1:0] val;
        case (nib)
            8'h96: val = 6'd0;   8'h97: val = 6'd1;   8'h9A: val = 6'd2;   8'h9B: val = 6'd3;
            8'h9D: val = 6'd4;   8'h9E: val = 6'd5;   8'h9F: val = 6'd6;   8'hA6: val = 6'd7;
            8'hA7: val = 6'd8;   8'hAB: val = 6'd9;   8'hAC: val = 6'd10;  8'hAD: val = 6'd11;
            8'hAE: val = 6'd12;  8'hAF: val = 6'd13;  8'hB2: val = 6'd14;  8'hB3: val = 6'd15;
            8'hB4: val = 6'd16;  8'hB5: val = 6'd17;  8'hB6: val = 6'd18;  8'hB7: val = 6'd19;
            8'hB9: val = 6'd20;  8'hBA: val = 6'd21;  8'hBB: val = 6'd22;  8'hBC: val = 6'd23;
            8'hBD: val = 6'd24;  8'hBE: val = 6'd25;  8'hBF: val = 6'd26;  8'hCB: val = 6'd27;
            8'hCD: val = 6'd28;  8'hCE: val = 6'd29;  8'hCF: val = 6'd30;  8'hD3: val = 6'd31;
            8'hD6: val = 6'd32;  8'hD7: val = 6'd33;  8'hD9: val = 6'd34;  8'hDA: val = 6'd35;
            8'hDB: val = 6'd36;  8'hDC: val = 6'd37;  8'hDD: val = 6'd38;  8'hDE: val = 6'd39;
            8'hDF: val = 6'd40;  8'hE5: val = 6'd41;  8'hE6: val = 6'd42;  8'hE7: val = 6'd43;
            8'hE9: val = 6'd44;  8'hEA: val = 6'd45;  8'hEB: val = 6'd46;  8'hEC: val = 6'd47;
            8'hED: val = 6'd48;  8'hEE: val = 6'd49;  8'hEF: val = 6'd50;  8'hF2: val = 6'd51;
            8'hF3: val = 6'd52;  8'hF4: val = 6'd53;  8'hF5: val = 6'd54;  8'hF6: val = 6'd55;
            8'hF7: val = 6'd56;  8'hF9: val = 6'd57;  8'hFA: val = 6'd58;  8'hFB: val = 6'd59;
            8'hFC: val = 6'd60;  8'hFD: val = 6'd61;  8'hFE: val = 6'd62;  8'hFF: val = 6'd63;
            default: val = 6'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/gcrdf_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module gcrdf_ram #(
    parameter int unsigned WIDTH = 6,
    parameter int unsigned DEPTH = 86
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on we, capture read data on re
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gcrdf_ctrl.sv =====
// Framing state machine: prolog/epilog hunt, address field decode, data nibble chain
// and store addressing. Uses gcrdf_pkg for constants, the inverse table and mem_req_t.
module gcrdf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          nib,
    output gcrdf_pkg::mem_req_t req
);

    typedef enum logic [4:0] {
        PH_HUNT_D5, PH_HUNT_AA, PH_HUNT_96,
        PH_VOL_A, PH_VOL_B, PH_TRK_A, PH_TRK_B, PH_SEC_A, PH_SEC_B,
        PH_CKS_A, PH_CKS_B, PH_EPI_DE, PH_EPI_AA,
        PH_DAT_D5, PH_DAT_AA, PH_DAT_AD, PH_DATA
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic [7:0]                         pair_first_reg, pair_first_next;
    logic [gcrdf_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [gcrdf_pkg::LOW_W-1:0]        chain_reg, chain_next;
    logic [gcrdf_pkg::LOW_AW-1:0]       slot_reg, slot_next;
    logic [gcrdf_pkg::GRP_W-1:0]        grp_reg, grp_next;
    logic [7:0]                         track_reg, track_next;
    logic [7:0]                         sector_reg, sector_next;
    logic [7:0]                         pair_val;
    logic [gcrdf_pkg::LOW_W-1:0]        chain_mix;
    logic [gcrdf_pkg::CNT_W-1:0]        idx_full;

    // Decode a 4-and-4 pair and fold the next data nibble into the chain
    assign pair_val  = ({pair_first_reg[6:0], 1'b0} & gcrdf_pkg::PAIR_HI_MASK)
                     | (nib & gcrdf_pkg::PAIR_LO_MASK);
    assign chain_mix = chain_reg ^ gcrdf_pkg::gcr_inverse(nib);
    assign idx_full  = count_reg - gcrdf_pkg::CNT_LOW_END;

    // Next-state logic
    always_comb
    begin
        phase_next      = phase_reg;
        pair_first_next = pair_first_reg;
        count_next      = count_reg;
        chain_next      = chain_reg;
        slot_next       = slot_reg;
        grp_next        = grp_reg;
        track_next      = track_reg;
        sector_next     = sector_reg;
        req             = '0;
        req.chain       = chain_mix;
        req.idx         = idx_full[7:0];
        req.grp         = grp_reg;
        req.track       = track_reg;
        req.sector      = sector_reg;
        req.addr        = slot_reg;

        case (phase_reg)
            PH_HUNT_D5: if (nib == gcrdf_pkg::MARK_D5) phase_next = PH_HUNT_AA;
            PH_HUNT_AA: phase_next = (nib == gcrdf_pkg::MARK_AA) ? PH_HUNT_96 : PH_HUNT_D5;
            PH_HUNT_96: phase_next = (nib == gcrdf_pkg::MARK_96) ? PH_VOL_A : PH_HUNT_D5;
            PH_VOL_A:
            begin
                pair_first_next = nib;
                phase_next      = PH_VOL_B;
            end
            PH_VOL_B: phase_next = PH_TRK_A;
            PH_TRK_A:
            begin
                pair_first_next = nib;
                phase_next      = PH_TRK_B;
            end
            PH_TRK_B:
            begin
                track_next = pair_val;
                phase_next = PH_SEC_A;
            end
            PH_SEC_A:
            begin
                pair_first_next = nib;
                phase_next      = PH_SEC_B;
            end
            PH_SEC_B:
            begin
                sector_next = pair_val;
                phase_next  = PH_CKS_A;
            end
            PH_CKS_A: phase_next = PH_CKS_B;
            PH_CKS_B: phase_next = PH_EPI_DE;
            PH_EPI_DE: if (nib == gcrdf_pkg::MARK_DE) phase_next = PH_EPI_AA;
            PH_EPI_AA: phase_next = (nib == gcrdf_pkg::MARK_AA) ? PH_DAT_D5 : PH_EPI_DE;
            PH_DAT_D5: if (nib == gcrdf_pkg::MARK_D5) phase_next = PH_DAT_AA;
            PH_DAT_AA: phase_next = (nib == gcrdf_pkg::MARK_AA) ? PH_DAT_AD : PH_DAT_D5;
            PH_DAT_AD:
            begin
                if (nib == gcrdf_pkg::MARK_AD)
                begin
                    phase_next = PH_DATA;
                    count_next = '0;
                    chain_next = '0;
                    slot_next  = '0;
                    grp_next   = '0;
                end
                else
                begin
                    phase_next = PH_DAT_D5;
                end
            end
            PH_DATA:
            begin
                if (count_reg >= gcrdf_pkg::CNT_DATA_END)
                begin
                    // trailing checksum nibble: drop it and hunt again
                    phase_next = PH_HUNT_D5;
                    count_next = '0;
                end
                else if (count_reg < gcrdf_pkg::CNT_LOW_END)
                begin
                    // low-bit groups: store chained value at its own slot
                    chain_next = chain_mix;
                    count_next = count_reg + gcrdf_pkg::CNT_STEP;
                    req.wr_en  = 1'b1;
                    req.addr   = count_reg[gcrdf_pkg::LOW_AW-1:0];
                end
                else
                begin
                    // sector byte: read its low-bit slot, advance slot and group
                    chain_next = chain_mix;
                    count_next = count_reg + gcrdf_pkg::CNT_STEP;
                    req.rd_en  = 1'b1;
                    if (slot_reg == gcrdf_pkg::SLOT_LAST)
                    begin
                        slot_next = '0;
                        grp_next  = grp_reg + gcrdf_pkg::GRP_STEP;
                    end
                    else
                    begin
                        slot_next = slot_reg + gcrdf_pkg::SLOT_STEP;
                    end
                end
            end
            default: phase_next = PH_HUNT_D5;
        endcase
    end

    // Hold state; advance only on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT_D5;
            pair_first_reg <= '0;
            count_reg      <= '0;
            chain_reg      <= '0;
            slot_reg       <= '0;
            grp_reg        <= '0;
            track_reg      <= '0;
            sector_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            pair_first_reg <= pair_first_next;
            count_reg      <= count_next;
            chain_reg      <= chain_next;
            slot_reg       <= slot_next;
            grp_reg        <= grp_next;
            track_reg      <= track_next;
            sector_reg     <= sector_next;
        end
    end

`ifndef SYNTHESIS
    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && req.rd_en))
        else $error("store read and write requested for the same item");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= gcrdf_pkg::CNT_DATA_END)
        else $error("data count ran past the end of the data field");
    a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (grp_reg != 2'd3))
        else $error("low-bit group index out of range");
`endif

endmodule

// ===== rtl/gcr_6and2_sector_deframer.sv =====
// Top level of the 6-and-2 GCR sector deframer: framer, low-bit store and output stage.
// Depends on gcrdf_pkg, gcrdf_ctrl and gcrdf_ram.
// Throughput: one nibble item per cycle unless the output stage stalls; a sector byte is
// valid on m_tdata in the cycle after its nibble is accepted, as the store read is registered.
// Reset (rst_n, async, active low) restarts the prolog hunt and empties the output stage;
// the low-bit store is not cleared, each data field writes all 86 entries before reading.
module gcr_6and2_sector_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] nib_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] sector_byte, [15:8] byte_index,
                                   // [23:16] track_number, [31:24] sector_number
    output logic        m_tlast    // last
);

    gcrdf_pkg::mem_req_t              req;
    logic                             accept;
    logic [gcrdf_pkg::LOW_W-1:0]      low_rdata;
    logic                             out_valid_reg;
    logic [gcrdf_pkg::LOW_W-1:0]      out_chain_reg;
    logic [7:0]                       out_idx_reg;
    logic [gcrdf_pkg::GRP_W-1:0]      out_grp_reg;
    logic [7:0]                       out_track_reg;
    logic [7:0]                       out_sector_reg;
    logic [1:0]                       low_pair;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    gcrdf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .nib    (s_tdata),
        .req    (req)
    );

    gcrdf_ram #(
        .WIDTH (gcrdf_pkg::LOW_W),
        .DEPTH (gcrdf_pkg::LOW_COUNT)
    ) u_low_store (
        .clk   (clk),
        .we    (accept && req.wr_en),
        .re    (accept && req.rd_en),
        .addr  (req.addr),
        .wdata (req.chain),
        .rdata (low_rdata)
    );

    // Output stage valid: load on a byte item, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= req.rd_en;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output stage payload, in step with the store read
    always_ff @(posedge clk)
    begin
        if (accept && req.rd_en)
        begin
            out_chain_reg  <= req.chain;
            out_idx_reg    <= req.idx;
            out_grp_reg    <= req.grp;
            out_track_reg  <= req.track;
            out_sector_reg <= req.sector;
        end
    end

    // Pick the two low bits for this group, swapped within the pair
    always_comb
    begin
        case (out_grp_reg)
            2'd0:    low_pair = {low_rdata[0], low_rdata[1]};
            2'd1:    low_pair = {low_rdata[2], low_rdata[3]};
            2'd2:    low_pair = {low_rdata[4], low_rdata[5]};
            default: low_pair = 2'b00;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sector_reg, out_track_reg, out_idx_reg, out_chain_reg, low_pair};
    assign m_tlast  = (out_idx_reg == 8'hFF);

`ifndef SYNTHESIS
    a_byte_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.rd_en) |=> m_tvalid)
        else $error("sector byte item missing after store read");
    a_no_write_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !(accept && req.wr_en))
        else $error("item accepted while output stage stalled");
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("sector byte item changed while stalled");
`endif

endmodule

// ===== verif/tb_gcr_6and2_sector_deframer.sv =====
// Self-checking testbench for gcr_6and2_sector_deframer: nibble stream in, sector bytes out.
// Depends on gcrdf_pkg for the field marks and data field sizes; predicts every byte itself.
`timescale 1ns / 1ps

module tb_gcr_6and2_sector_deframer;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 350;
    localparam int REPORT_MAX   = 10;

    // Deframer phases as tracked by the predictor
    typedef enum logic [4:0] {
        SEEK_ADDR_D5, SEEK_ADDR_AA, SEEK_ADDR_96,
        VOL_HI, VOL_LO, TRK_HI, TRK_LO, SEC_HI, SEC_LO, CKS_HI, CKS_LO,
        SEEK_EPI_DE, SEEK_EPI_AA,
        SEEK_DATA_D5, SEEK_DATA_AA, SEEK_DATA_AD,
        TAKE_DATA
    } field_phase_t;

    // One rebuilt sector byte, laid out as {m_tdata, m_tlast}
    typedef struct packed {
        logic [7:0] sec_id;
        logic [7:0] trk_id;
        logic [7:0] index;
        logic [7:0] value;
        logic       last;
    } sector_byte_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // 6-and-2 disk code, value k is written as disk_code[k]
    logic [7:0] disk_code [0:63] = '{
        8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
        8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
        8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
        8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
        8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
        8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
        8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
        8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
    };

    // Predictor state
    field_phase_t ph        = SEEK_ADDR_D5;
    logic [7:0]   pair_hi   = 8'h00;
    logic [8:0]   nib_count = 9'd0;
    logic [5:0]   chain     = 6'd0;
    logic [5:0]   low_bits [0:gcrdf_pkg::LOW_COUNT-1];
    logic [7:0]   cur_trk   = 8'h00;
    logic [7:0]   cur_sec   = 8'h00;

    sector_byte_t byte_q [$];

    int nibs_sent     = 0;
    int bytes_checked = 0;
    int fields_done   = 0;
    int err_count     = 0;
    int idle_cycles   = 0;
    bit running       = 1'b0;

    // Sender burst state and receiver pattern state
    int burst_left = 0;
    int rdy_mode   = 0;
    int rdy_left   = 0;
    int rdy_tick   = 0;

    gcr_6and2_sector_deframer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // Map a disk nibble back to its 6-bit value; nibbles outside the code give 0
    function automatic logic [5:0] code_value(input logic [7:0] nib);
        logic [5:0] val;
        val = 6'd0;
        for (int k = 0; k < 64; k++)
            if (disk_code[k] == nib)
                val = 6'(k);
        return val;
    endfunction

    // Rebuild an address byte from its 4-and-4 pair
    function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
        return ((hi << 1) & gcrdf_pkg::PAIR_HI_MASK) | (lo & gcrdf_pkg::PAIR_LO_MASK);
    endfunction

    // Format one sector byte for a report line
    function automatic string show(input sector_byte_t b);
        return $sformatf("trk %02h sec %02h idx %0d data %02h last %0b",
                         b.trk_id, b.sec_id, b.index, b.value, b.last);
    endfunction

    // Advance the predicted deframer by one nibble; queue the sector byte it yields
    function automatic void track_nibble(input logic [7:0] nib);
        logic [7:0]   idx;
        int           slot;
        int           sh;
        logic [5:0]   lows;
        sector_byte_t want;
        case (ph)
            SEEK_ADDR_D5: if (nib == gcrdf_pkg::MARK_D5) ph = SEEK_ADDR_AA;
            SEEK_ADDR_AA: ph = (nib == gcrdf_pkg::MARK_AA) ? SEEK_ADDR_96 : SEEK_ADDR_D5;
            SEEK_ADDR_96: ph = (nib == gcrdf_pkg::MARK_96) ? VOL_HI : SEEK_ADDR_D5;
            VOL_HI, TRK_HI, SEC_HI:
            begin
                pair_hi = nib;
                ph = field_phase_t'(ph + 5'd1);
            end
            VOL_LO: ph = TRK_HI;
            TRK_LO:
            begin
                cur_trk = pair_value(pair_hi, nib);
                ph = SEC_HI;
            end
            SEC_LO:
            begin
                cur_sec = pair_value(pair_hi, nib);
                ph = CKS_HI;
            end
            CKS_HI: ph = CKS_LO;
            CKS_LO: ph = SEEK_EPI_DE;
            SEEK_EPI_DE: if (nib == gcrdf_pkg::MARK_DE) ph = SEEK_EPI_AA;
            SEEK_EPI_AA: ph = (nib == gcrdf_pkg::MARK_AA) ? SEEK_DATA_D5 : SEEK_EPI_DE;
            SEEK_DATA_D5: if (nib == gcrdf_pkg::MARK_D5) ph = SEEK_DATA_AA;
            SEEK_DATA_AA: ph = (nib == gcrdf_pkg::MARK_AA) ? SEEK_DATA_AD : SEEK_DATA_D5;
            SEEK_DATA_AD:
            begin
                if (nib == gcrdf_pkg::MARK_AD)
                begin
                    ph = TAKE_DATA;
                    nib_count = 9'd0;
                    chain = 6'd0;
                end
                else
                    ph = SEEK_DATA_D5;
            end
            TAKE_DATA:
            begin
                if (nib_count >= gcrdf_pkg::DATA_COUNT)
                begin
                    // trailing checksum nibble: swallow it and go back to hunting
                    ph = SEEK_ADDR_D5;
                    nib_count = 9'd0;
                    fields_done++;
                end
                else
                begin
                    chain = chain ^ code_value(nib);
                    if (nib_count < gcrdf_pkg::LOW_COUNT)
                        low_bits[nib_count] = chain;
                    else
                    begin
                        idx  = 8'(nib_count - gcrdf_pkg::LOW_COUNT);
                        slot = int'(idx) % gcrdf_pkg::LOW_COUNT;
                        sh   = 2 * (int'(idx) / gcrdf_pkg::LOW_COUNT);
                        lows = low_bits[slot];
                        want.value  = {chain, lows[sh], lows[sh + 1]};
                        want.index  = idx;
                        want.trk_id = cur_trk;
                        want.sec_id = cur_sec;
                        want.last   = (idx == 8'hff);
                        byte_q.push_back(want);
                    end
                    nib_count = nib_count + 9'd1;
                end
            end
            default: ph = SEEK_ADDR_D5;
        endcase
    endfunction

    // Predict on every accepted nibble, check every accepted sector byte
    always @(posedge clk)
    begin
        sector_byte_t got;
        sector_byte_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                track_nibble(s_tdata);
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata, m_tlast};
                bytes_checked++;
                if (byte_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("%0t: unexpected sector byte %0s", $realtime, show(got));
                end
                else
                begin
                    want = byte_q.pop_front();
                    if (got !== want)
                    begin
                        err_count++;
                        if (err_count <= REPORT_MAX)
                        begin
                            $display("%0t: byte mismatch, expected %0s", $realtime, show(want));
                            $display("%0t:                got      %0s", $realtime, show(got));
                        end
                    end
                end
            end
        end
    end

    // Receiver: switch between randomly chosen stall patterns
    always @(posedge clk)
    begin
        rdy_tick <= rdy_tick + 1;
        if (rdy_left == 0)
        begin
            rdy_mode <= $urandom_range(0, 3);
            rdy_left <= $urandom_range(20, 150);
        end
        else
            rdy_left <= rdy_left - 1;
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (rdy_tick % 5 == 2);
            default: m_tready <= (rdy_tick % 16 < 10);
        endcase
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge clk)
    begin
        if (!running || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d sector bytes still due",
                     $realtime, idle_cycles, byte_q.size());
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Send one nibble; open a gap between random bursts
    task automatic send_nib(input logic [7:0] nib);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= nib;
        do
            @(posedge clk);
        while (!s_tready);
        nibs_sent++;
    endtask

    // Send one byte as a 4-and-4 pair
    task automatic send_pair(input logic [7:0] v);
        send_nib(((v >> 1) & gcrdf_pkg::PAIR_LO_MASK) | gcrdf_pkg::PAIR_HI_MASK);
        send_nib((v & gcrdf_pkg::PAIR_LO_MASK) | gcrdf_pkg::PAIR_HI_MASK);
    endtask

    // Send a well-formed address field with epilog
    task automatic send_addr_field(input logic [7:0] vol, input logic [7:0] trk,
                                   input logic [7:0] sec);
        send_nib(gcrdf_pkg::MARK_D5);
        send_nib(gcrdf_pkg::MARK_AA);
        send_nib(gcrdf_pkg::MARK_96);
        send_pair(vol);
        send_pair(trk);
        send_pair(sec);
        send_pair(vol ^ trk ^ sec);
        send_nib(gcrdf_pkg::MARK_DE);
        send_nib(gcrdf_pkg::MARK_AA);
        send_nib(8'heb);
    endtask

    // Send a data field; bad_pct percent of the nibbles are random bytes, which may fall outside the code
    task automatic send_data_field(input int bad_pct);
        send_nib(gcrdf_pkg::MARK_D5);
        send_nib(gcrdf_pkg::MARK_AA);
        send_nib(gcrdf_pkg::MARK_AD);
        for (int i = 0; i <= gcrdf_pkg::DATA_COUNT; i++)
            if ($urandom_range(0, 99) < bad_pct)
                send_nib(8'($urandom_range(0, 255)));
            else
                send_nib(disk_code[$urandom_range(0, 63)]);
    endtask

    // Broken marks, a repeated mark byte and extreme address bytes
    task automatic test_mark_recovery();
        send_nib(8'h00);
        send_nib(8'hff);
        // second D5 fails the hunt and is not taken as a new first byte
        send_nib(gcrdf_pkg::MARK_D5);
        send_nib(gcrdf_pkg::MARK_D5);
        send_nib(gcrdf_pkg::MARK_AA);
        send_nib(gcrdf_pkg::MARK_96);
        send_nib(gcrdf_pkg::MARK_D5);
        send_nib(gcrdf_pkg::MARK_AA);
        send_nib(8'h95);
        send_nib(gcrdf_pkg::MARK_D5);
        send_nib(gcrdf_pkg::MARK_AA);
        send_nib(gcrdf_pkg::MARK_96);
        // volume and checksum are read and dropped
        send_nib(8'hff);
        send_nib(8'hff);
        send_pair(8'hff);
        send_pair(8'h00);
        send_nib(8'h00);
        send_nib(8'hff);
        // bad epilog, then a repeated DE
        send_nib(gcrdf_pkg::MARK_DE);
        send_nib(8'hab);
        send_nib(gcrdf_pkg::MARK_DE);
        send_nib(gcrdf_pkg::MARK_DE);
        send_nib(gcrdf_pkg::MARK_DE);
        send_nib(gcrdf_pkg::MARK_AA);
        // bad data prolog; the field that follows comes from the next test
        send_nib(gcrdf_pkg::MARK_D5);
        send_nib(gcrdf_pkg::MARK_AA);
        send_nib(8'hac);
    endtask

    // Data fields with every nibble value and with extreme low-bit groups
    task automatic test_sector_extremes();
        send_nib(gcrdf_pkg::MARK_D5);
        send_nib(gcrdf_pkg::MARK_AA);
        send_nib(gcrdf_pkg::MARK_AD);
        for (int i = 0; i < gcrdf_pkg::DATA_COUNT; i++)
            send_nib((i < 256) ? 8'(i) : disk_code[(i - 256) % 64]);
        send_nib(8'h00);

        send_addr_field(8'hfe, 8'h00, 8'hff);
        send_nib(gcrdf_pkg::MARK_D5);
        send_nib(gcrdf_pkg::MARK_AA);
        send_nib(gcrdf_pkg::MARK_AD);
        for (int i = 0; i < gcrdf_pkg::DATA_COUNT; i++)
            send_nib((i < gcrdf_pkg::LOW_COUNT || i % 2 == 0) ? disk_code[63] : disk_code[0]);
        send_nib(8'hff);
    endtask

    // Mostly whole sectors with random content, mixed with noise and broken fields
    task automatic test_random_stream();
        int start;
        int pick;
        int n;
        start = nibs_sent;
        while (nibs_sent - start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 6)
            begin
                repeat ($urandom_range(0, 8)) send_nib(8'hff);
                send_addr_field(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 5)) send_nib(8'hff);
                send_data_field((pick == 0) ? 40 : 5);
            end
            else if (pick == 7)
            begin
                n = $urandom_range(4, 20);
                repeat (n) send_nib(8'($urandom_range(0, 255)));
            end
            else if (pick == 8)
            begin
                // address field cut short, or a data prolog broken at its last byte
                send_nib(gcrdf_pkg::MARK_D5);
                send_nib(gcrdf_pkg::MARK_AA);
                if ($urandom_range(0, 1) == 0)
                    send_nib(disk_code[$urandom_range(1, 63)]);
                else
                begin
                    send_nib(gcrdf_pkg::MARK_96);
                    repeat ($urandom_range(0, 7)) send_nib(8'($urandom_range(0, 255)));
                end
            end
            else
                // no data field: the next address prolog is swallowed by the data hunt
                send_addr_field(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        running = 1'b1;

        test_mark_recovery();
        test_sector_extremes();
        test_random_stream();
        s_tvalid <= 1'b0;

        // drain, then let the registered output stage settle
        while (byte_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d nibbles over %0d complete data fields; %0d sector bytes checked.",
                 nibs_sent, fields_done, bytes_checked);
        $display("Mismatches or unexpected bytes: %0d, bytes still due: %0d.",
                 err_count, byte_q.size());
        if (err_count == 0 && byte_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
